// ----- rtl/ptw_pkg.sv -----
package ptw_pkg;

  // Field widths of one request word and of one table entry.
  localparam int OP_W    = 2;
  localparam int VP_W    = 36;
  localparam int PFN_W   = 40;
  localparam int FLAG_W  = 12;
  localparam int ENTRY_W = 64;

  // Table geometry.
  localparam int IDX_W      = 9;
  localparam int ENTRIES    = 512;
  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int NF_W       = $clog2(NUM_FRAMES + 1);
  localparam int ADDR_W     = FRAME_W + IDX_W;
  localparam int DEPTH      = NUM_FRAMES * ENTRIES;
  localparam int LVL_W      = 2;

  // Request opcodes. The reserved code changes nothing and answers with zeros.
  localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNMAP = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  // Walk levels.
  localparam logic [LVL_W-1:0] LVL_PML4 = 2'd0;
  localparam logic [LVL_W-1:0] LVL_PDPT = 2'd1;
  localparam logic [LVL_W-1:0] LVL_PD   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_PT   = 2'd3;

  // Entry bit positions.
  localparam int BIT_PRESENT = 0;
  localparam int BIT_USER    = 2;
  localparam int BIT_HUGE    = 7;
  localparam int PFN_LSB     = 12;
  localparam int PFN_MSB     = 51;

  // Controller to datapath commands.
  typedef struct packed {
    logic in_ready;
    logic load_req;
    logic mem_rd;
    logic clr_wr;
    logic alloc;
    logic link_wr;
    logic leaf_wr;
    logic follow;
    logic set_status;
    logic set_mapped;
    logic out_load;
  } ptw_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic              in_valid;
    logic [OP_W-1:0]   op;
    logic [LVL_W-1:0]  lvl;
    logic              present;
    logic              huge;
    logic              full;
    logic              clr_last;
    logic              out_busy;
  } ptw_sts_t;

endpackage

// ----- rtl/ptw_if.sv -----
interface ptw_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptw_pkg::OP_W-1:0]     op;
  logic [ptw_pkg::VP_W-1:0]     virt_page;
  logic [ptw_pkg::PFN_W-1:0]    phys_frame;
  logic [ptw_pkg::FLAG_W-1:0]   page_flags;
  logic                         no_execute;

  modport source (output valid, op, virt_page, phys_frame, page_flags, no_execute,
                  input ready);
  modport sink (input valid, op, virt_page, phys_frame, page_flags, no_execute,
                output ready);
endinterface

interface ptw_out_if;
  logic valid;
  logic ready;
  logic status;
  logic is_mapped;

  modport source (output valid, status, is_mapped, input ready);
  modport sink (input valid, status, is_mapped, output ready);
endinterface

// ----- rtl/ptw_ctrl.sv -----
module ptw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  ptw_pkg::ptw_sts_t sts,
  output ptw_pkg::ptw_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_FILL  = 8'b0001_0000,
    S_LINK  = 8'b0010_0000,
    S_LEAF  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        if (sts.op == ptw_pkg::OP_MAP || sts.op == ptw_pkg::OP_UNMAP ||
            sts.op == ptw_pkg::OP_QUERY) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EVAL: begin
        case (sts.op)
          ptw_pkg::OP_MAP: begin
            if (sts.present) begin
              cmd.follow = 1'b1;
              state_nxt  = (sts.lvl == ptw_pkg::LVL_PD) ? S_LEAF : S_RD;
            end else if (sts.full) begin
              cmd.set_status = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              cmd.alloc = 1'b1;
              state_nxt = S_FILL;
            end
          end
          ptw_pkg::OP_UNMAP: begin
            if (!sts.present) begin
              state_nxt = S_DONE;
            end else begin
              cmd.follow = 1'b1;
              state_nxt  = (sts.lvl == ptw_pkg::LVL_PD) ? S_LEAF : S_RD;
            end
          end
          ptw_pkg::OP_QUERY: begin
            if (sts.lvl == ptw_pkg::LVL_PT) begin
              cmd.set_mapped = sts.present;
              state_nxt      = S_DONE;
            end else if (!sts.present) begin
              state_nxt = S_DONE;
            end else if (sts.lvl == ptw_pkg::LVL_PD && sts.huge) begin
              cmd.set_mapped = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              cmd.follow = 1'b1;
              state_nxt  = S_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FILL: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_LINK;
      end
      S_LINK: begin
        cmd.link_wr = 1'b1;
        state_nxt   = (sts.lvl == ptw_pkg::LVL_PD) ? S_LEAF : S_RD;
      end
      S_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ----- rtl/ptw_dp.sv -----
module ptw_dp (
  input  logic              clk,
  input  logic              rst_n,
  ptw_in_if.sink            in_ch,
  ptw_out_if.source         out_ch,
  input  ptw_pkg::ptw_cmd_t cmd,
  output ptw_pkg::ptw_sts_t sts
);

  // Table store: NUM_FRAMES frames of ENTRIES words each.
  logic [ptw_pkg::ENTRY_W-1:0] mem [ptw_pkg::DEPTH];

  logic [ptw_pkg::OP_W-1:0]    op_r;
  logic [ptw_pkg::VP_W-1:0]    vp_r;
  logic [ptw_pkg::PFN_W-1:0]   pfn_r;
  logic [ptw_pkg::FLAG_W-1:0]  flags_r;
  logic                        nx_r;

  logic [ptw_pkg::FRAME_W-1:0] frame_r;
  logic                        frame_oob_r;
  logic [ptw_pkg::LVL_W-1:0]   lvl_r;
  logic [ptw_pkg::ENTRY_W-1:0] rdata_r;

  logic [ptw_pkg::NF_W-1:0]    next_free_r;
  logic [ptw_pkg::FRAME_W-1:0] alloc_frame_r;
  logic [ptw_pkg::IDX_W-1:0]   clr_cnt_r;

  logic                        status_r;
  logic                        mapped_r;
  logic                        out_valid_r;
  logic                        out_status_r;
  logic                        out_mapped_r;

  logic [ptw_pkg::IDX_W-1:0]   idx;
  logic [ptw_pkg::ADDR_W-1:0]  walk_addr;
  logic [ptw_pkg::ADDR_W-1:0]  wr_addr;
  logic [ptw_pkg::ENTRY_W-1:0] wr_data;
  logic                        wr_en;
  logic [ptw_pkg::PFN_W-1:0]   entry_pfn;
  logic                        entry_oob;
  logic [ptw_pkg::ENTRY_W-1:0] link_entry;
  logic [ptw_pkg::ENTRY_W-1:0] leaf_entry;

  always_comb begin
    case (lvl_r)
      ptw_pkg::LVL_PML4: idx = vp_r[35:27];
      ptw_pkg::LVL_PDPT: idx = vp_r[26:18];
      ptw_pkg::LVL_PD:   idx = vp_r[17:9];
      default:           idx = vp_r[8:0];
    endcase
  end

  assign walk_addr = {frame_r, idx};
  assign entry_pfn = rdata_r[ptw_pkg::PFN_MSB:ptw_pkg::PFN_LSB];
  assign entry_oob = (entry_pfn >= ptw_pkg::PFN_W'(ptw_pkg::NUM_FRAMES));

  // New table entries carry present, writable and the request's user bit.
  assign link_entry = {12'b0,
                       {(ptw_pkg::PFN_W - ptw_pkg::FRAME_W){1'b0}}, alloc_frame_r,
                       9'b0, flags_r[ptw_pkg::BIT_USER], 2'b11};
  assign leaf_entry = (op_r == ptw_pkg::OP_MAP) ?
                      {nx_r, 11'b0, pfn_r, flags_r | ptw_pkg::FLAG_W'(1)} : '0;

  // A frame number past the store discards writes to it.
  assign wr_en   = cmd.clr_wr || ((cmd.link_wr || cmd.leaf_wr) && !frame_oob_r);
  assign wr_addr = cmd.clr_wr ? {alloc_frame_r, clr_cnt_r} : walk_addr;
  assign wr_data = cmd.clr_wr ? '0 : (cmd.link_wr ? link_entry : leaf_entry);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rdata_r <= mem[walk_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r    <= in_ch.op;
      vp_r    <= in_ch.virt_page;
      pfn_r   <= in_ch.phys_frame;
      flags_r <= in_ch.page_flags;
      nx_r    <= in_ch.no_execute;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r       <= '0;
      frame_oob_r   <= 1'b0;
      lvl_r         <= '0;
      next_free_r   <= ptw_pkg::NF_W'(1);
      alloc_frame_r <= '0;
      clr_cnt_r     <= '0;
      status_r      <= 1'b0;
      mapped_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        frame_r     <= '0;
        frame_oob_r <= 1'b0;
        lvl_r       <= '0;
        status_r    <= 1'b0;
        mapped_r    <= 1'b0;
      end
      if (cmd.follow) begin
        frame_r     <= entry_pfn[ptw_pkg::FRAME_W-1:0];
        frame_oob_r <= entry_oob;
        lvl_r       <= lvl_r + 1'b1;
      end
      if (cmd.link_wr) begin
        frame_r     <= alloc_frame_r;
        frame_oob_r <= 1'b0;
        lvl_r       <= lvl_r + 1'b1;
      end
      if (cmd.alloc) begin
        alloc_frame_r <= next_free_r[ptw_pkg::FRAME_W-1:0];
        next_free_r   <= next_free_r + 1'b1;
      end
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.set_status) status_r <= 1'b1;
      if (cmd.set_mapped) mapped_r <= 1'b1;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_mapped_r <= mapped_r;
    end
  end

  assign in_ch.ready      = cmd.in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.is_mapped = out_mapped_r;

  assign sts.in_valid = in_ch.valid;
  assign sts.op       = op_r;
  assign sts.lvl      = lvl_r;
  assign sts.present  = !frame_oob_r && rdata_r[ptw_pkg::BIT_PRESENT];
  assign sts.huge     = rdata_r[ptw_pkg::BIT_HUGE];
  assign sts.full     = (next_free_r == ptw_pkg::NF_W'(ptw_pkg::NUM_FRAMES));
  assign sts.clr_last = (clr_cnt_r == '1);
  assign sts.out_busy = out_valid_r && !out_ch.ready;

endmodule

// ----- rtl/four_level_page_table_engine.sv -----
// Four-level page table walker over an internal single-port table store of
// NUM_FRAMES frames of 512 64-bit entries; frame 0 is the root table. One
// request is handled at a time. Every level of a walk is one store read
// followed by one decision; each table that map has to allocate is first
// zeroed one entry per cycle through the store's single write port and then
// linked. After reset the root frame is zeroed the same way, and in_ch.ready
// stays low until that clear is done. The result word sits in an output
// register, so a new request is taken while the previous result waits.
module four_level_page_table_engine (
  input  logic       clk,
  input  logic       rst_n,
  ptw_in_if.sink     in_ch,
  ptw_out_if.source  out_ch
);

  ptw_pkg::ptw_cmd_t cmd;
  ptw_pkg::ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ptw_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  // Only one request is in flight: ready drops right after an accept.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while a walk was in flight");

  // A frame is never handed out once the store is exhausted.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !sts.full)
    else $error("frame allocated past the end of the store");

  // The store port serves at most one access per cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mem_rd, cmd.clr_wr, cmd.link_wr, cmd.leaf_wr}))
    else $error("conflicting table store accesses");

  // Out-of-frames only comes from map, which never reports a mapping.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.status && out_ch.is_mapped))
    else $error("result carries both out-of-frames and mapped");

endmodule
